// ===== src/ppt_pkg.sv =====
// shared types and constants for the pedal plausibility torque request unit
package ppt_pkg;

    localparam int unsigned RAW_W    = 16;
    localparam int unsigned PEDAL_W  = 10;
    localparam int unsigned LIMIT_W  = 12;
    localparam int unsigned TENTHS_W = 15;
    localparam int unsigned PROD_W   = 2 * RAW_W;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [RAW_W-1:0]   PCT25_LEVEL       = 16'd160;
    localparam logic [RAW_W-1:0]   PCT5_LEVEL        = 16'd104;
    localparam logic [RAW_W-1:0]   BRAKE_LIGHT_LEVEL = 16'd50;
    localparam logic [LIMIT_W-1:0] LIMIT_CAP         = 12'd3000;

    // quotient bits produced by the divider, one per cycle
    localparam int unsigned DIV_STEPS = LIMIT_W;
    localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_APPS_MIN     = 3'd0,
        CFG_APPS_MAX     = 3'd1,
        CFG_ACCEL_START  = 3'd2,
        CFG_WIDE_OPEN    = 3'd3,
        CFG_TORQUE_LIMIT = 3'd4,
        CFG_SECOND_RECIP = 3'd5,
        CFG_AGREE_MARGIN = 3'd6,
        CFG_HARD_BRAKE   = 3'd7
    } cfg_idx_t;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MUL_S = 6'b000010,
        ST_EVAL  = 6'b000100,
        ST_MUL_T = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

endpackage

// ===== src/ppt_pedal_if.sv =====
// pedal sample channel
interface ppt_pedal_if;
    logic                      valid;
    logic                      ready;
    logic [ppt_pkg::RAW_W-1:0] pedal_a;
    logic [ppt_pkg::RAW_W-1:0] pedal_b;
    logic [ppt_pkg::RAW_W-1:0] brake_level;
    logic                      drive_active;

    modport source (output valid, pedal_a, pedal_b, brake_level, drive_active, input ready);
    modport sink (input valid, pedal_a, pedal_b, brake_level, drive_active, output ready);
endinterface

// ===== src/ppt_result_if.sv =====
// torque request result channel
interface ppt_result_if;
    logic                         valid;
    logic                         ready;
    logic [ppt_pkg::TENTHS_W-1:0] torque_tenths;
    logic                         sensor_fault;
    logic                         sensor_mismatch;
    logic                         brake_cut;
    logic                         brake_light;

    modport source (output valid, torque_tenths, sensor_fault, sensor_mismatch, brake_cut,
                    brake_light, input ready);
    modport sink (input valid, torque_tenths, sensor_fault, sensor_mismatch, brake_cut,
                  brake_light, output ready);
endinterface

// ===== src/ppt_cfg_if.sv =====
// configuration register write channel
interface ppt_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ppt_pkg::CFG_IDX_W-1:0]  index;
    logic [ppt_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== src/pedal_plausibility_torque_request_unit.sv =====
// pedal plausibility check and torque request, shared multiplier and serial divider
//
// pedal: one word per sample (two accelerator readings, brake reading, drive flag).
// result: one word per sample with torque in tenths of Nm and the fault flags.
// cfg: register writes, always ready; write only while no sample is in flight.
// a sample is taken only when the sequencer is idle; it then runs through
// one multiply for the second sensor scaling, an evaluate step, and, when
// a torque ramp value is needed, a second multiply on the same multiplier and
// a restoring divide by the pedal span (one quotient bit a cycle).
// the sequencer takes a new word in the cycle after the result is loaded.
// the result sits in an output register until taken; a stalled receiver holds
// it there, and the next sample can be processed as far as the done state meanwhile.
// reset restores the default register values and sets the brake latch to
// torque allowed; no result is pending after reset.
module pedal_plausibility_torque_request_unit (
    input  logic       clk,
    input  logic       rst_n,
    ppt_pedal_if.sink  pedal,
    ppt_result_if.source result,
    ppt_cfg_if.sink    cfg
);

    ppt_pkg::state_t state_reg, state_next;

    // configuration
    logic [ppt_pkg::PEDAL_W-1:0] apps_min_reg, apps_max_reg, accel_start_reg, wide_open_reg;
    logic [ppt_pkg::PEDAL_W-1:0] agree_margin_reg;
    logic [ppt_pkg::LIMIT_W-1:0] torque_limit_reg;
    logic [ppt_pkg::RAW_W-1:0]   second_recip_reg, hard_brake_reg;

    logic brake_ok_reg, brake_ok_next;
    logic out_valid_reg, out_valid_next;
    logic [ppt_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    // payload
    logic [ppt_pkg::RAW_W-1:0]    a_reg, b_reg, brk_reg;
    logic                         drive_reg;
    logic [ppt_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic [ppt_pkg::PEDAL_W-1:0]  x_reg, x_next;
    logic [ppt_pkg::PEDAL_W-1:0]  rem_reg, rem_next;
    logic [ppt_pkg::LIMIT_W-1:0]  div_reg, div_next;
    logic                         fault_reg, fault_next;
    logic                         mism_reg, mism_next;
    logic                         light_reg, light_next;
    logic [ppt_pkg::TENTHS_W-1:0] tenths_reg, tenths_next;
    logic                         o_fault_reg, o_mism_reg, o_cut_reg, o_light_reg;

    logic in_fire, out_load;

    // shared multiplier
    logic [ppt_pkg::RAW_W-1:0]  mul_a, mul_b;
    logic [ppt_pkg::PROD_W-1:0] product;

    // evaluate path
    logic [ppt_pkg::RAW_W-1:0]   s_val, diff, avg, x_full;
    logic [ppt_pkg::RAW_W:0]     sum;
    logic [ppt_pkg::RAW_W-1:0]   min_ext, max_ext, as_ext;
    logic                        in_range, mism, fault, hard, high25, low5, latch_new;
    logic [ppt_pkg::PEDAL_W-1:0] span;
    logic [ppt_pkg::LIMIT_W-1:0] lim;

    // divider step
    logic [ppt_pkg::PEDAL_W:0] trial;
    logic                      ge;

    assign pedal.ready  = (state_reg == ppt_pkg::ST_IDLE);
    assign cfg.ready    = 1'b1;
    assign in_fire      = pedal.valid && pedal.ready;
    assign out_load     = (state_reg == ppt_pkg::ST_DONE) && (!out_valid_reg || result.ready);

    assign result.valid           = out_valid_reg;
    assign result.torque_tenths   = tenths_reg;
    assign result.sensor_fault    = o_fault_reg;
    assign result.sensor_mismatch = o_mism_reg;
    assign result.brake_cut       = o_cut_reg;
    assign result.brake_light     = o_light_reg;

    assign span = wide_open_reg - accel_start_reg;
    assign lim  = (torque_limit_reg > ppt_pkg::LIMIT_CAP) ? ppt_pkg::LIMIT_CAP : torque_limit_reg;

    assign mul_a   = (state_reg == ppt_pkg::ST_MUL_T) ? ppt_pkg::RAW_W'(x_reg) : b_reg;
    assign mul_b   = (state_reg == ppt_pkg::ST_MUL_T) ? ppt_pkg::RAW_W'(lim) : second_recip_reg;
    assign product = ppt_pkg::PROD_W'(mul_a) * ppt_pkg::PROD_W'(mul_b);

    assign s_val   = prod_reg[ppt_pkg::PROD_W-1:ppt_pkg::RAW_W];
    assign min_ext = ppt_pkg::RAW_W'(apps_min_reg);
    assign max_ext = ppt_pkg::RAW_W'(apps_max_reg);
    assign as_ext  = ppt_pkg::RAW_W'(accel_start_reg);

    assign in_range = (a_reg > min_ext) && (a_reg < max_ext)
                   && (s_val > min_ext) && (s_val < max_ext);
    assign diff     = (a_reg >= s_val) ? (a_reg - s_val) : (s_val - a_reg);
    assign mism     = in_range && (diff > ppt_pkg::RAW_W'(agree_margin_reg));
    assign fault    = !in_range || mism;
    assign hard     = brk_reg > hard_brake_reg;
    assign high25   = (a_reg > ppt_pkg::PCT25_LEVEL) || (s_val > ppt_pkg::PCT25_LEVEL);
    assign low5     = (a_reg < ppt_pkg::PCT5_LEVEL) && (s_val < ppt_pkg::PCT5_LEVEL);

    always_comb
    begin
        latch_new = brake_ok_reg;
        if (drive_reg)
        begin
            if (hard && high25)
                latch_new = 1'b0;
            else if (low5)
                latch_new = 1'b1;
        end
    end

    assign sum    = {1'b0, a_reg} + {1'b0, s_val};
    assign avg    = sum[ppt_pkg::RAW_W:1];
    assign x_full = avg - as_ext;

    assign trial = {rem_reg, div_reg[ppt_pkg::LIMIT_W-1]};
    assign ge    = trial >= {1'b0, span};

    always_comb
    begin
        state_next     = state_reg;
        brake_ok_next  = brake_ok_reg;
        out_valid_next = out_valid_reg;
        cnt_next       = cnt_reg;
        prod_next      = prod_reg;
        x_next         = x_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        fault_next     = fault_reg;
        mism_next      = mism_reg;
        light_next     = light_reg;
        tenths_next    = tenths_reg;

        if (out_valid_reg && result.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ppt_pkg::ST_IDLE:
            begin
                if (in_fire)
                    state_next = ppt_pkg::ST_MUL_S;
            end
            ppt_pkg::ST_MUL_S:
            begin
                prod_next  = product;
                state_next = ppt_pkg::ST_EVAL;
            end
            ppt_pkg::ST_EVAL:
            begin
                brake_ok_next = latch_new;
                fault_next    = fault;
                mism_next     = mism;
                light_next    = brk_reg > ppt_pkg::BRAKE_LIGHT_LEVEL;
                x_next        = x_full[ppt_pkg::PEDAL_W-1:0];
                if (!(drive_reg && !fault && latch_new) || (avg <= as_ext))
                begin
                    div_next   = '0;
                    state_next = ppt_pkg::ST_DONE;
                end
                else if ((wide_open_reg <= accel_start_reg)
                         || (x_full >= ppt_pkg::RAW_W'(span)))
                begin
                    // past wide open throttle, or no ramp span: clamp to the limit
                    div_next   = lim;
                    state_next = ppt_pkg::ST_DONE;
                end
                else
                    state_next = ppt_pkg::ST_MUL_T;
            end
            ppt_pkg::ST_MUL_T:
            begin
                // x < span, so the product fits 22 bits and the quotient 12
                rem_next   = product[ppt_pkg::LIMIT_W +: ppt_pkg::PEDAL_W];
                div_next   = product[ppt_pkg::LIMIT_W-1:0];
                cnt_next   = '0;
                state_next = ppt_pkg::ST_DIV;
            end
            ppt_pkg::ST_DIV:
            begin
                rem_next = ge ? ppt_pkg::PEDAL_W'(trial - {1'b0, span})
                              : trial[ppt_pkg::PEDAL_W-1:0];
                div_next = {div_reg[ppt_pkg::LIMIT_W-2:0], ge};
                cnt_next = cnt_reg + ppt_pkg::CNT_W'(1);
                if (cnt_reg == ppt_pkg::CNT_W'(ppt_pkg::DIV_STEPS - 1))
                    state_next = ppt_pkg::ST_DONE;
            end
            ppt_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    tenths_next    = ppt_pkg::TENTHS_W'({div_reg, 3'b000})
                                   + ppt_pkg::TENTHS_W'({div_reg, 1'b0});
                    out_valid_next = 1'b1;
                    state_next     = ppt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ppt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ppt_pkg::ST_IDLE;
            brake_ok_reg     <= 1'b1;
            out_valid_reg    <= 1'b0;
            cnt_reg          <= '0;
            apps_min_reg     <= 10'd20;
            apps_max_reg     <= 10'd900;
            accel_start_reg  <= 10'd190;
            wide_open_reg    <= 10'd290;
            torque_limit_reg <= 12'd230;
            second_recip_reg <= 16'd49276;
            agree_margin_reg <= 10'd37;
            hard_brake_reg   <= 16'd100;
        end
        else
        begin
            state_reg     <= state_next;
            brake_ok_reg  <= brake_ok_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            if (cfg.valid && cfg.ready)
            begin
                case (ppt_pkg::cfg_idx_t'(cfg.index))
                    ppt_pkg::CFG_APPS_MIN:     apps_min_reg     <= cfg.data[ppt_pkg::PEDAL_W-1:0];
                    ppt_pkg::CFG_APPS_MAX:     apps_max_reg     <= cfg.data[ppt_pkg::PEDAL_W-1:0];
                    ppt_pkg::CFG_ACCEL_START:  accel_start_reg  <= cfg.data[ppt_pkg::PEDAL_W-1:0];
                    ppt_pkg::CFG_WIDE_OPEN:    wide_open_reg    <= cfg.data[ppt_pkg::PEDAL_W-1:0];
                    ppt_pkg::CFG_TORQUE_LIMIT: torque_limit_reg <= cfg.data[ppt_pkg::LIMIT_W-1:0];
                    ppt_pkg::CFG_SECOND_RECIP: second_recip_reg <= cfg.data;
                    ppt_pkg::CFG_AGREE_MARGIN: agree_margin_reg <= cfg.data[ppt_pkg::PEDAL_W-1:0];
                    ppt_pkg::CFG_HARD_BRAKE:   hard_brake_reg   <= cfg.data;
                    default:                   ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_reg     <= pedal.pedal_a;
            b_reg     <= pedal.pedal_b;
            brk_reg   <= pedal.brake_level;
            drive_reg <= pedal.drive_active;
        end
        prod_reg   <= prod_next;
        x_reg      <= x_next;
        rem_reg    <= rem_next;
        div_reg    <= div_next;
        fault_reg  <= fault_next;
        mism_reg   <= mism_next;
        light_reg  <= light_next;
        tenths_reg <= tenths_next;
        if (out_load)
        begin
            o_fault_reg <= fault_reg;
            o_mism_reg  <= mism_reg;
            o_cut_reg   <= !brake_ok_reg;
            o_light_reg <= light_reg;
        end
    end

endmodule

// ===== bench/tb_pedal_plausibility_torque_request_unit.sv =====
// self-checking testbench for the pedal plausibility torque request unit
`timescale 1ns / 1ps

module tb_pedal_plausibility_torque_request_unit;

    // pedal thresholds as the predictor sees them
    localparam int unsigned QUARTER_PEDAL  = 160;
    localparam int unsigned RELEASE_PEDAL  = 104;
    localparam int unsigned LIGHT_LEVEL    = 50;
    localparam int unsigned TORQUE_CAP_NM  = 3000;
    // about 470 words plus hold-off and drains, many times over
    localparam int unsigned CYCLE_LIMIT    = 400000;
    localparam int unsigned RANDOM_PHASES  = 8;

    typedef struct packed {
        logic [ppt_pkg::RAW_W-1:0] pedal_a;
        logic [ppt_pkg::RAW_W-1:0] pedal_b;
        logic [ppt_pkg::RAW_W-1:0] brake_level;
        logic                      drive_active;
    } pedal_sample_t;

    typedef struct packed {
        logic [ppt_pkg::TENTHS_W-1:0] torque_tenths;
        logic                         sensor_fault;
        logic                         sensor_mismatch;
        logic                         brake_cut;
        logic                         brake_light;
    } torque_word_t;

    typedef struct packed {
        pedal_sample_t smp;
        logic          known;
        torque_word_t  known_word;
    } directed_row_t;

    logic clk;
    logic rst_n;

    ppt_pedal_if  pedal_ch ();
    ppt_result_if result_ch ();
    ppt_cfg_if    cfg_ch ();

    pedal_plausibility_torque_request_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pedal  (pedal_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // predictor copy of the registers and the brake latch
    logic [ppt_pkg::PEDAL_W-1:0] win_lo;
    logic [ppt_pkg::PEDAL_W-1:0] win_hi;
    logic [ppt_pkg::PEDAL_W-1:0] ramp_start;
    logic [ppt_pkg::PEDAL_W-1:0] ramp_full;
    logic [ppt_pkg::LIMIT_W-1:0] limit_nm;
    logic [ppt_pkg::RAW_W-1:0]   b_recip;
    logic [ppt_pkg::PEDAL_W-1:0] margin;
    logic [ppt_pkg::RAW_W-1:0]   hard_level;
    logic                        brake_ok;

    torque_word_t  expected_words [$];
    directed_row_t directed_rows [$];

    int unsigned cycle_count;
    int unsigned fail_count;
    int unsigned words_checked;
    int unsigned samples_sent;
    int unsigned settings_applied;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_cycles;
    torque_word_t chk_want;
    torque_word_t chk_got;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic in_window(int unsigned v);
        return v > 32'(win_lo) && v < 32'(win_hi);
    endfunction

    function automatic torque_word_t predict_torque_word(pedal_sample_t smp);
        longint unsigned prod;
        int unsigned a;
        int unsigned s;
        int unsigned diff;
        int unsigned avg;
        int unsigned lim;
        int unsigned nm;
        logic in_rng;
        logic mis;
        logic flt;
        torque_word_t w;
        a = 32'(smp.pedal_a);
        prod = longint'(smp.pedal_b) * longint'(b_recip);
        s = int'(prod >> 16);
        in_rng = in_window(a) && in_window(s);
        diff = a > s ? a - s : s - a;
        mis = in_rng && diff > 32'(margin);
        flt = !in_rng || mis;
        if (smp.drive_active)
        begin
            if (smp.brake_level > hard_level && (a > QUARTER_PEDAL || s > QUARTER_PEDAL))
                brake_ok = 1'b0;
            else if (a < RELEASE_PEDAL && s < RELEASE_PEDAL)
                brake_ok = 1'b1;
        end
        nm = 0;
        if (smp.drive_active && !flt && brake_ok)
        begin
            avg = (a + s) / 2;
            lim = 32'(limit_nm) > TORQUE_CAP_NM ? TORQUE_CAP_NM : 32'(limit_nm);
            if (avg <= 32'(ramp_start))
                nm = 0;
            else if (ramp_full <= ramp_start)
                nm = lim;
            else
            begin
                nm = ((avg - 32'(ramp_start)) * lim) / (32'(ramp_full) - 32'(ramp_start));
                if (nm > lim)
                    nm = lim;
            end
        end
        w.torque_tenths = ppt_pkg::TENTHS_W'(nm * 10);
        w.sensor_fault = flt;
        w.sensor_mismatch = mis;
        w.brake_cut = !brake_ok;
        w.brake_light = 32'(smp.brake_level) > LIGHT_LEVEL;
        return w;
    endfunction

    function automatic int unsigned clip16(int v);
        if (v < 0)
            return 0;
        if (v > 65535)
            return 65535;
        return v;
    endfunction

    // mostly sensor pairs that track each other, with noise and broken pairs mixed in
    function automatic pedal_sample_t make_sample();
        pedal_sample_t smp;
        int p;
        int lo;
        int hi;
        int off;
        int unsigned zone;
        if ($urandom_range(0, 99) < 15)
        begin
            smp.pedal_a = ppt_pkg::RAW_W'($urandom);
            smp.pedal_b = ppt_pkg::RAW_W'($urandom);
            smp.brake_level = ppt_pkg::RAW_W'($urandom);
            smp.drive_active = 1'($urandom);
            return smp;
        end
        zone = $urandom_range(0, 3);
        lo = int'(win_lo) + 1;
        hi = int'(win_hi) - 1;
        case (zone)
            0: p = $urandom_range(0, 110);
            1: p = (lo <= hi) ? $urandom_range(lo, hi) : $urandom_range(0, 1023);
            2: p = $urandom_range(140, 200);
            default: p = $urandom_range(0, 1023);
        endcase
        off = 0;
        if ($urandom_range(0, 4) == 0)
            off = int'($urandom_range(0, 2 * margin + 20)) - int'(margin) - 10;
        smp.pedal_a = ppt_pkg::RAW_W'(clip16(p + off));
        // smallest b whose scaled value lands on p
        if (b_recip == 0)
            smp.pedal_b = ppt_pkg::RAW_W'($urandom);
        else
            smp.pedal_b = ppt_pkg::RAW_W'(clip16(int'(((longint'(p) << 16) + b_recip - 1)
                                                      / b_recip)));
        case ($urandom_range(0, 2))
            0: smp.brake_level = ppt_pkg::RAW_W'($urandom_range(0, 60));
            1: smp.brake_level = ppt_pkg::RAW_W'(clip16(int'(hard_level)
                                                       + int'($urandom_range(0, 4)) - 2));
            default: smp.brake_level = ppt_pkg::RAW_W'($urandom);
        endcase
        smp.drive_active = $urandom_range(0, 9) != 0;
        return smp;
    endfunction

    task automatic write_reg(input ppt_pkg::cfg_idx_t idx, input int unsigned value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= ppt_pkg::CFG_DATA_W'(value);
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            ppt_pkg::CFG_APPS_MIN:     win_lo = ppt_pkg::PEDAL_W'(value);
            ppt_pkg::CFG_APPS_MAX:     win_hi = ppt_pkg::PEDAL_W'(value);
            ppt_pkg::CFG_ACCEL_START:  ramp_start = ppt_pkg::PEDAL_W'(value);
            ppt_pkg::CFG_WIDE_OPEN:    ramp_full = ppt_pkg::PEDAL_W'(value);
            ppt_pkg::CFG_TORQUE_LIMIT: limit_nm = ppt_pkg::LIMIT_W'(value);
            ppt_pkg::CFG_SECOND_RECIP: b_recip = ppt_pkg::RAW_W'(value);
            ppt_pkg::CFG_AGREE_MARGIN: margin = ppt_pkg::PEDAL_W'(value);
            ppt_pkg::CFG_HARD_BRAKE:   hard_level = ppt_pkg::RAW_W'(value);
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic apply_setting(input int unsigned lo, input int unsigned hi,
                                 input int unsigned start, input int unsigned full,
                                 input int unsigned lim, input int unsigned recip,
                                 input int unsigned marg, input int unsigned hard);
        write_reg(ppt_pkg::CFG_APPS_MIN, lo);
        write_reg(ppt_pkg::CFG_APPS_MAX, hi);
        write_reg(ppt_pkg::CFG_ACCEL_START, start);
        write_reg(ppt_pkg::CFG_WIDE_OPEN, full);
        write_reg(ppt_pkg::CFG_TORQUE_LIMIT, lim);
        write_reg(ppt_pkg::CFG_SECOND_RECIP, recip);
        write_reg(ppt_pkg::CFG_AGREE_MARGIN, marg);
        write_reg(ppt_pkg::CFG_HARD_BRAKE, hard);
        cfg_ch.valid <= 1'b0;
        settings_applied++;
    endtask

    // wait until every word is back, then let the sequencer settle
    task automatic wait_idle();
        while (expected_words.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic send_sample(input pedal_sample_t smp, input logic known,
                               input torque_word_t known_word);
        torque_word_t w;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            pedal_ch.valid <= 1'b0;
            @(negedge clk);
        end
        pedal_ch.valid <= 1'b1;
        pedal_ch.pedal_a <= smp.pedal_a;
        pedal_ch.pedal_b <= smp.pedal_b;
        pedal_ch.brake_level <= smp.brake_level;
        pedal_ch.drive_active <= smp.drive_active;
        @(posedge clk);
        while (!pedal_ch.ready)
            @(posedge clk);
        // predictor always runs so the latch copy follows typed rows too
        w = predict_torque_word(smp);
        expected_words.push_back(known ? known_word : w);
        samples_sent++;
        @(negedge clk);
    endtask

    task automatic add_row(input int unsigned a, input int unsigned b, input int unsigned brk,
                           input int unsigned drv, input int unsigned known,
                           input int unsigned tenths, input int unsigned flt,
                           input int unsigned mis, input int unsigned cut,
                           input int unsigned light);
        directed_row_t r;
        r.smp.pedal_a = ppt_pkg::RAW_W'(a);
        r.smp.pedal_b = ppt_pkg::RAW_W'(b);
        r.smp.brake_level = ppt_pkg::RAW_W'(brk);
        r.smp.drive_active = 1'(drv);
        r.known = 1'(known);
        r.known_word.torque_tenths = ppt_pkg::TENTHS_W'(tenths);
        r.known_word.sensor_fault = 1'(flt);
        r.known_word.sensor_mismatch = 1'(mis);
        r.known_word.brake_cut = 1'(cut);
        r.known_word.brake_light = 1'(light);
        directed_rows.push_back(r);
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, expected_words.size());
            $display("pedal_plausibility_torque_request_unit verification failed");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_cycles != 0)
        begin
            result_ch.ready <= 1'b0;
            hold_cycles--;
        end
        else
            result_ch.ready <= $urandom_range(0, 99) >= recv_stall_pct;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            chk_got.torque_tenths = result_ch.torque_tenths;
            chk_got.sensor_fault = result_ch.sensor_fault;
            chk_got.sensor_mismatch = result_ch.sensor_mismatch;
            chk_got.brake_cut = result_ch.brake_cut;
            chk_got.brake_light = result_ch.brake_light;
            if (expected_words.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected word at cycle %0d: tenths=%0d flt=%b mis=%b cut=%b lt=%b",
                             cycle_count, chk_got.torque_tenths, chk_got.sensor_fault,
                             chk_got.sensor_mismatch, chk_got.brake_cut, chk_got.brake_light);
            end
            else
            begin
                chk_want = expected_words.pop_front();
                words_checked++;
                if (chk_got !== chk_want)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"word %0d mismatch: tenths exp %0d got %0d, flt exp %b got %b, ",
                                  "mis exp %b got %b, cut exp %b got %b, lt exp %b got %b"},
                                 words_checked, chk_want.torque_tenths, chk_got.torque_tenths,
                                 chk_want.sensor_fault, chk_got.sensor_fault,
                                 chk_want.sensor_mismatch, chk_got.sensor_mismatch,
                                 chk_want.brake_cut, chk_got.brake_cut,
                                 chk_want.brake_light, chk_got.brake_light);
                end
            end
        end
    end

    initial
    begin
        int unsigned n_items;
        int unsigned mode;
        int unsigned st;
        int unsigned fw;
        logic paced;
        directed_row_t r;

        rst_n = 1'b0;
        pedal_ch.valid = 1'b0;
        pedal_ch.pedal_a = '0;
        pedal_ch.pedal_b = '0;
        pedal_ch.brake_level = '0;
        pedal_ch.drive_active = 1'b0;
        result_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = ppt_pkg::CFG_APPS_MIN;
        cfg_ch.data = '0;
        cycle_count = 0;
        fail_count = 0;
        words_checked = 0;
        samples_sent = 0;
        settings_applied = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        // reset values
        win_lo = 10'd20;
        win_hi = 10'd900;
        ramp_start = 10'd190;
        ramp_full = 10'd290;
        limit_nm = 12'd230;
        b_recip = 16'd49276;
        margin = 10'd37;
        hard_level = 16'd100;
        brake_ok = 1'b1;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed rows run on the reset register values
        add_row(0, 0, 0, 0,                 1, 0, 1, 0, 0, 0);
        add_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, 0, 1, 0, 1, 1);
        add_row(0, 0, 0, 1,                 1, 0, 1, 0, 0, 0);
        add_row(400, 532, 0, 1,             1, 2300, 0, 0, 0, 0);
        add_row(240, 320, 0, 1,             0, 0, 0, 0, 0, 0);
        add_row(200, 266, 0, 1,             0, 0, 0, 0, 0, 0);
        add_row(500, 532, 0, 1,             1, 0, 1, 1, 0, 0);
        add_row(437, 532, 0, 1,             1, 2300, 0, 0, 0, 0);
        add_row(438, 532, 0, 1,             1, 0, 1, 1, 0, 0);
        add_row(100, 133, 50, 1,            1, 0, 0, 0, 0, 0);
        add_row(100, 133, 51, 1,            1, 0, 0, 0, 0, 1);
        // brake exactly at the hard level, then pedal exactly at a quarter
        add_row(161, 215, 100, 1,           1, 0, 0, 0, 0, 1);
        add_row(160, 214, 200, 1,           1, 0, 0, 0, 0, 1);
        add_row(161, 215, 101, 1,           1, 0, 0, 0, 1, 1);
        add_row(161, 215, 0, 1,             1, 0, 0, 0, 1, 0);
        add_row(400, 532, 0, 1,             1, 0, 0, 0, 1, 0);
        // latch releases only with both sensors under the release level
        add_row(103, 139, 0, 1,             1, 0, 0, 0, 1, 0);
        add_row(103, 138, 0, 1,             1, 0, 0, 0, 0, 0);
        add_row(21, 28, 0, 1,               1, 0, 0, 0, 0, 0);
        add_row(20, 28, 0, 1,               1, 0, 1, 0, 0, 0);
        add_row(899, 1196, 0, 1,            1, 2300, 0, 0, 0, 0);
        add_row(900, 1196, 0, 1,            1, 0, 1, 0, 0, 0);
        add_row(400, 532, 0, 0,             1, 0, 0, 0, 0, 0);
        add_row(400, 532, 200, 0,           1, 0, 0, 0, 0, 1);

        foreach (directed_rows[i])
        begin
            r = directed_rows[i];
            send_sample(r.smp, r.known, r.known_word);
        end
        pedal_ch.valid <= 1'b0;

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_idle();
            case (ph)
                0: apply_setting(20, 900, 190, 290, 230, 49276, 37, 100);
                1: apply_setting(0, 1023, 0, 1023, 4095, 65535, 0, 0);
                2: apply_setting(10, 600, 400, 400, 3000, 32768, 1023, 65535);
                3: apply_setting(1023, 0, 1023, 1, 0, 0, 5, 50);
                default:
                begin
                    st = $urandom_range(0, 600);
                    if ($urandom_range(0, 3) == 0)
                        fw = $urandom_range(0, st);
                    else
                        fw = st + $urandom_range(1, 400);
                    if (fw > 1023)
                        fw = 1023;
                    apply_setting($urandom_range(0, 200), $urandom_range(400, 1023), st, fw,
                                  $urandom_range(0, 4095), $urandom_range(30000, 65535),
                                  $urandom_range(0, 200), $urandom_range(0, 2000));
                end
            endcase
            mode = ph % 4;
            send_idle_pct = (mode == 1) ? 85 : (mode == 3) ? 36 : 0;
            recv_stall_pct = (mode == 2) ? 85 : (mode == 3) ? 36 : 0;
            paced = (ph == 5);
            n_items = (ph == 3) ? 30 : 60;
            // long receiver hold-off while words keep coming, so the input backs up
            if (ph == 0)
                hold_cycles = 300;
            for (int k = 0; k < n_items; k++)
            begin
                if (paced && k != 0)
                begin
                    pedal_ch.valid <= 1'b0;
                    while (expected_words.size() != 0)
                        @(negedge clk);
                end
                send_sample(make_sample(), 1'b0, '0);
            end
            pedal_ch.valid <= 1'b0;
        end

        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("covered %0d pedal samples over %0d register settings, %0d words checked",
                 samples_sent, settings_applied + 1, words_checked);
        $display("idle, sender gaps, receiver stalls and a 300 cycle hold-off all exercised");
        if (fail_count == 0 && expected_words.size() == 0)
            $display("pedal_plausibility_torque_request_unit verification clean");
        else
        begin
            $display("%0d failures, %0d words never arrived", fail_count, expected_words.size());
            $display("pedal_plausibility_torque_request_unit verification failed");
        end
        $finish;
    end

endmodule
